### design/rip_pkg.sv
// ----------------------------------------------------------------------------
// rip_pkg
// Shared types and constants for the reuse interval profiler.
// ----------------------------------------------------------------------------
package rip_pkg;

	// input opcodes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_DEL   = 2'd2;
	localparam logic [1:0] OP_END   = 2'd3;

	// report kinds
	localparam logic [1:0] KIND_SUM = 2'd0;
	localparam logic [1:0] KIND_BIN = 2'd1;
	localparam logic [1:0] KIND_FR  = 2'd2;
	localparam logic [1:0] KIND_RUN = 2'd3;

	localparam int          TIME_W       = 40;
	localparam int          NRT_W        = 41;
	localparam int          ENTRY_W      = TIME_W + 2;  // valid, first-reuse done, time
	localparam int          DVD_W        = 64;
	localparam int          DSR_W        = 40;
	localparam logic [3:0]  LAST_BIN     = 4'd11;
	localparam logic [39:0] IV_RESET     = 40'd900000;
	localparam logic [31:0] MAX32        = 32'hFFFF_FFFF;

	// ms to minutes: 60000 = 32 * 1875, so drop 5 bits and divide by 1875.
	// The 37-bit quotient input splits at bit 18; 2^18 = 1875 * 139 + 1519.
	// The leftover (under 2^30) is divided by a reciprocal multiply that is
	// exact for every 30-bit value.
	localparam logic [7:0]  MIN_Q_HI     = 8'd139;
	localparam logic [10:0] MIN_R_HI     = 11'd1519;
	localparam logic [30:0] MIN_RECIP    = 31'd1172812403;  // ceil(2^41 / 1875)

	// one classified transaction as it sits in the queue
	typedef struct packed {
		logic [1:0]  op;
		logic [39:0] time_ms;
		logic [15:0] key;
		logic [31:0] bytes;
		logic        key_ok;
	} item_t;

	// status from the back part to the front part
	typedef struct packed {
		logic clearing;
	} back_stat_t;

	// reuse interval to bin number; negative intervals fall in bin 0
	function automatic logic [3:0] bin_of(input logic signed [40:0] d);
		logic [3:0] b;
		logic [9:0] d10;
		b   = 4'd1;
		d10 = d[9:0];
		if (d < 41'sd50) begin
			b = 4'd0;
		end else if (d >= 41'sd1000) begin
			b = LAST_BIN;
		end else begin
			for (int j = 1; j < 10; j++) begin
				if (d10 >= 10'(100 * j)) b = b + 4'd1;
			end
		end
		return b;
	endfunction

endpackage

### design/rip_ram.sv
// ----------------------------------------------------------------------------
// rip_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

### design/rip_front.sv
// ----------------------------------------------------------------------------
// rip_front
// Accepts transactions, flags keys outside the table, and queues them
// (two entries) for the back part.
// ----------------------------------------------------------------------------
module rip_front #(
	parameter int KEY_COUNT = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          opcode,
	input  logic [39:0]         time_ms,
	input  logic [15:0]         object_key,
	input  logic [31:0]         object_bytes,
	input  rip_pkg::back_stat_t stat,
	input  logic                pop,
	output logic                busy,
	output logic                item_valid,
	output rip_pkg::item_t      item
);
	import rip_pkg::*;

	item_t      fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      cls;

	// classify the incoming transaction
	always_comb begin
		cls.op      = opcode;
		cls.time_ms = time_ms;
		cls.key     = object_key;
		cls.bytes   = object_bytes;
		cls.key_ok  = (32'(object_key) < 32'(KEY_COUNT));
	end

	assign busy       = (cnt_q == 2'd2) || stat.clearing;
	assign push       = start && !busy;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = fifo_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cls;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

### design/rip_div.sv
// ----------------------------------------------------------------------------
// rip_div
// Shared restoring divider, one quotient bit per cycle (64 steps; done
// pulses with the final quotient).
// ----------------------------------------------------------------------------
module rip_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [39:0] divisor,
	output logic        done,
	output logic [63:0] quotient,
	output logic [39:0] remainder
);
	import rip_pkg::*;

	logic [63:0] quo_q;
	logic [40:0] rem_q;
	logic [39:0] dsr_q;
	logic [5:0]  step_q;
	logic        run_q, done_q;
	logic [40:0] rem_sh;
	logic        fits;

	assign rem_sh    = {rem_q[39:0], quo_q[63]};
	assign fits      = (rem_sh >= {1'b0, dsr_q});
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[39:0];

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[62:0], fits};
			rem_q <= fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 6'd1;
				if (step_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

### design/rip_back.sv
// ----------------------------------------------------------------------------
// rip_back
// Executes queued transactions: clears the key table after reset, closes
// intervals and emits reports, and updates the key table and histograms.
// ----------------------------------------------------------------------------
module rip_back #(
	parameter int KEY_COUNT = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [39:0]         cfg_wr_data,
	input  logic                item_valid,
	input  rip_pkg::item_t      item,
	output logic                pop,
	output rip_pkg::back_stat_t stat,
	output logic                strobe,
	output logic [1:0]          report_kind,
	output logic [34:0]         report_minute,
	output logic [3:0]          bin_index,
	output logic [31:0]         count_value,
	output logic [31:0]         mean_bytes,
	output logic                last_of_run
);
	import rip_pkg::*;

	localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

	// minute pipeline: cnt_q steps at which the first and second stamps are captured
	localparam logic [3:0] MIN_CAP1 = 4'd2;
	localparam logic [3:0] MIN_CAP2 = 4'd3;

	typedef enum logic [11:0] {
		S_CLEAR = 12'b000000000001,
		S_IDLE  = 12'b000000000010,
		S_DIVK  = 12'b000000000100,
		S_DIVM  = 12'b000000001000,
		S_MIN   = 12'b000000010000,
		S_SUM   = 12'b000000100000,
		S_BIN   = 12'b000001000000,
		S_RUN   = 12'b000010000000,
		S_FR    = 12'b000100000000,
		S_ACC   = 12'b001000000000,
		S_RD    = 12'b010000000000,
		S_FIN   = 12'b100000000000
	} state_t;

	state_t         state_q;
	item_t          cur_q;
	logic [39:0]    iv_q;
	logic [40:0]    nrt_q, nrt_new_q;
	logic [31:0]    runs_q, mean_q, read_cnt_q;
	logic [63:0]    sum_q;
	logic [34:0]    min1_q, min2_q;
	logic [31:0]    ibins_q [12];
	logic [31:0]    fbins_q [12];
	logic [3:0]     cnt_q;
	logic [AW-1:0]  clr_q;
	logic           div_go_q;

	// divider hookup
	logic [63:0]    div_dvd, div_quo;
	logic [39:0]    div_dsr, div_rem;
	logic           div_done;

	// minute stamp pipeline
	logic [41:0]    min_x;
	logic [18:0]    min_yh;
	logic [17:0]    min_yl;
	logic [26:0]    mq_s1, mq_s2;
	logic [29:0]    mr_s1;
	logic [60:0]    mp_s2;
	logic [34:0]    min_val;

	// key table
	logic               ram_we;
	logic [AW-1:0]      ram_waddr, key_addr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

	// entry fields and reuse bin
	logic               ent_valid, ent_done;
	logic [39:0]        ent_time;
	logic signed [40:0] delta;
	logic [3:0]         bin;
	logic [64:0]        sum_add;
	logic [63:0]        runs_wide;

	assign key_addr  = AW'(cur_q.key);
	assign ent_valid = ram_rdata[ENTRY_W-1];
	assign ent_done  = ram_rdata[ENTRY_W-2];
	assign ent_time  = ram_rdata[TIME_W-1:0];
	assign delta     = $signed({1'b0, cur_q.time_ms}) - $signed({1'b0, ent_time});
	assign bin       = bin_of(delta);
	assign sum_add   = {1'b0, sum_q} + 65'(cur_q.bytes);
	assign runs_wide = (div_rem != '0) ? div_quo : (div_quo - 64'd1);
	assign stat.clearing = (state_q == S_CLEAR);
	assign pop       = (state_q == S_IDLE) && item_valid;

	// divider operands follow the state that launched it
	always_comb begin
		div_dvd = 64'({1'b0, cur_q.time_ms} - nrt_q);
		div_dsr = iv_q;
		case (state_q)
			S_DIVM: begin
				div_dvd = sum_q;
				div_dsr = 40'(read_cnt_q);
			end
			default: begin
				div_dvd = 64'({1'b0, cur_q.time_ms} - nrt_q);
				div_dsr = iv_q;
			end
		endcase
	end

	rip_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_go_q),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// minute stamps: closed interval end first, then the next interval end
	assign min_x   = (cnt_q == 4'd0) ? {1'b0, nrt_q}
		: ({1'b0, nrt_q} + {2'b00, iv_q});
	assign min_yh  = min_x[41:23];
	assign min_yl  = min_x[22:5];
	assign min_val = 35'(mq_s2) + 35'(mp_s2[60:41]);

	always_ff @(posedge clk) begin
		mq_s1 <= 27'(min_yh) * 27'(MIN_Q_HI);
		mr_s1 <= 30'(min_yh) * 30'(MIN_R_HI) + 30'(min_yl);
		mq_s2 <= mq_s1;
		mp_s2 <= 61'(mr_s1) * 61'(MIN_RECIP);
	end

	// key table writes: clearing sweep or update
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = key_addr;
		ram_wdata = {1'b1, ent_done | ent_valid, cur_q.time_ms};
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_RD:    ram_we = 1'b1;
			default: ram_we = 1'b0;
		endcase
	end

	rip_ram #(.WIDTH(ENTRY_W), .DEPTH(KEY_COUNT)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (key_addr),
		.rdata (ram_rdata)
	);

	// captured transaction and close-time scratch
	always_ff @(posedge clk) begin
		if (pop) cur_q <= item;
		if (state_q == S_DIVK && div_done) begin
			runs_q    <= (runs_wide > 64'(MAX32)) ? MAX32 : runs_wide[31:0];
			nrt_new_q <= {1'b0, cur_q.time_ms} - 41'(div_rem)
				+ ((div_rem != '0) ? 41'(iv_q) : 41'd0);
		end
		if (state_q == S_DIVK && div_done && read_cnt_q == '0) mean_q <= '0;
		if (state_q == S_DIVM && div_done)
			mean_q <= (div_quo > 64'(MAX32)) ? MAX32 : div_quo[31:0];
		if (state_q == S_MIN && cnt_q == MIN_CAP1) min1_q <= min_val;
		if (state_q == S_MIN && cnt_q == MIN_CAP2) min2_q <= min_val;
	end

	// result register
	always_ff @(posedge clk) begin
		report_kind   <= KIND_SUM;
		report_minute <= '0;
		bin_index     <= '0;
		count_value   <= '0;
		mean_bytes    <= '0;
		last_of_run   <= 1'b0;
		case (state_q)
			S_SUM: begin
				report_minute <= min1_q;
				count_value   <= read_cnt_q;
				mean_bytes    <= mean_q;
			end
			S_BIN: begin
				report_kind   <= KIND_BIN;
				report_minute <= min1_q;
				bin_index     <= cnt_q;
				count_value   <= ibins_q[cnt_q];
				last_of_run   <= (cnt_q == LAST_BIN) && (runs_q == '0);
			end
			S_RUN: begin
				report_kind   <= KIND_RUN;
				report_minute <= min2_q;
				count_value   <= runs_q;
				last_of_run   <= 1'b1;
			end
			S_FR: begin
				report_kind <= KIND_FR;
				bin_index   <= cnt_q;
				count_value <= fbins_q[cnt_q];
				last_of_run <= (cnt_q == LAST_BIN);
			end
			default: report_kind <= KIND_SUM;
		endcase
	end

	// sequencer, counters and histograms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			cnt_q      <= '0;
			div_go_q   <= 1'b0;
			strobe     <= 1'b0;
			iv_q       <= IV_RESET;
			nrt_q      <= 41'(IV_RESET);
			read_cnt_q <= '0;
			sum_q      <= '0;
			for (int i = 0; i < 12; i++) begin
				ibins_q[i] <= '0;
				fbins_q[i] <= '0;
			end
		end else begin
			div_go_q <= 1'b0;
			strobe   <= (state_q == S_SUM) || (state_q == S_BIN)
				|| (state_q == S_RUN) || (state_q == S_FR);
			if (cfg_wr_en) begin
				iv_q  <= (cfg_wr_data == '0) ? 40'd1 : cfg_wr_data;
				nrt_q <= (cfg_wr_data == '0) ? 41'd1 : 41'(cfg_wr_data);
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(KEY_COUNT - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (item_valid) begin
						cnt_q <= '0;
						if (item.op == OP_END) begin
							state_q <= S_FR;
						end else if ({1'b0, item.time_ms} > nrt_q) begin
							state_q  <= S_DIVK;
							div_go_q <= 1'b1;
						end else if (item.op == OP_DEL) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_ACC;
						end
					end
				end
				S_DIVK: begin
					if (div_done) begin
						if (read_cnt_q != '0) begin
							div_go_q <= 1'b1;
							state_q  <= S_DIVM;
						end else begin
							state_q <= S_MIN;
						end
					end
				end
				S_DIVM: begin
					if (div_done) state_q <= S_MIN;
				end
				S_MIN: begin
					cnt_q <= (cnt_q == MIN_CAP2) ? 4'd0 : cnt_q + 4'd1;
					if (cnt_q == MIN_CAP2) state_q <= S_SUM;
				end
				S_SUM: begin
					read_cnt_q <= '0;
					sum_q      <= '0;
					state_q    <= S_BIN;
				end
				S_BIN: begin
					for (int i = 0; i < 12; i++) begin
						if (cnt_q == 4'(i)) ibins_q[i] <= '0;
					end
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == LAST_BIN) state_q <= (runs_q != '0) ? S_RUN : S_FIN;
				end
				S_RUN: state_q <= S_FIN;
				S_FIN: begin
					nrt_q   <= nrt_new_q;
					state_q <= (cur_q.op == OP_DEL) ? S_IDLE : S_ACC;
				end
				S_FR: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == LAST_BIN) state_q <= S_IDLE;
				end
				S_ACC: begin
					if (cur_q.op == OP_READ) begin
						if (read_cnt_q != MAX32) read_cnt_q <= read_cnt_q + 32'd1;
						sum_q <= sum_add[64] ? '1 : sum_add[63:0];
					end
					state_q <= cur_q.key_ok ? S_RD : S_IDLE;
				end
				S_RD: begin
					if (ent_valid) begin
						for (int i = 0; i < 12; i++) begin
							if (bin == 4'(i)) begin
								if (ibins_q[i] != MAX32) ibins_q[i] <= ibins_q[i] + 32'd1;
								if (!ent_done && fbins_q[i] != MAX32)
									fbins_q[i] <= fbins_q[i] + 32'd1;
							end
						end
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### design/reuse_interval_profiler.sv
// ----------------------------------------------------------------------------
// reuse_interval_profiler
// Reuse interval histograms per reporting interval and per key first reuse.
// ----------------------------------------------------------------------------
// After reset the block sweeps every entry of its key table with busy high.
// An access without an interval close passes through queue pop, key table
// read and read-modify-write, and ends after the read when the key is
// outside the table; a delete without close ends at the queue pop. A close
// runs the shared bit-serial divider for the interval count and, when the
// interval saw reads, for the mean read size; the two minute stamps follow,
// and the results then come one per cycle (summary, 12 bins, optional empty
// run), after which the new interval end is committed before the access
// itself. End of trace emits the 12 first-reuse bins. A two-entry queue
// lets start be taken while the back part works. Results appear for one
// cycle with strobe high; the receiver cannot stall them.
module reuse_interval_profiler #(
	parameter int KEY_COUNT = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [39:0] cfg_wr_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [39:0] time_ms,
	input  logic [15:0] object_key,
	input  logic [31:0] object_bytes,
	output logic        strobe,
	output logic [1:0]  report_kind,
	output logic [34:0] report_minute,
	output logic [3:0]  bin_index,
	output logic [31:0] count_value,
	output logic [31:0] mean_bytes,
	output logic        last_of_run
);
	import rip_pkg::*;

	item_t      item;
	logic       item_valid, pop;
	back_stat_t stat;

	rip_front #(.KEY_COUNT(KEY_COUNT)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.opcode       (opcode),
		.time_ms      (time_ms),
		.object_key   (object_key),
		.object_bytes (object_bytes),
		.stat         (stat),
		.pop          (pop),
		.busy         (busy),
		.item_valid   (item_valid),
		.item         (item)
	);

	rip_back #(.KEY_COUNT(KEY_COUNT)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.item_valid    (item_valid),
		.item          (item),
		.pop           (pop),
		.stat          (stat),
		.strobe        (strobe),
		.report_kind   (report_kind),
		.report_minute (report_minute),
		.bin_index     (bin_index),
		.count_value   (count_value),
		.mean_bytes    (mean_bytes),
		.last_of_run   (last_of_run)
	);
endmodule

### design/rip_checker.sv
// ----------------------------------------------------------------------------
// rip_checker
// Port-level checks on the report sequence of the profiler.
// ----------------------------------------------------------------------------
module rip_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       strobe,
	input logic [1:0] report_kind,
	input logic [3:0] bin_index,
	input logic       last_of_run
);
	import rip_pkg::*;

	// a summary is always followed by its bins
	a_sum_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && report_kind == KIND_SUM |-> !last_of_run)
		else $error("summary marked last");

	a_sum_then_bin: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && report_kind == KIND_SUM |=> strobe && report_kind == KIND_BIN
			&& bin_index == 4'd0)
		else $error("summary not followed by bin 0");

	// bins run back to back in order
	a_bin_seq: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (report_kind == KIND_BIN || report_kind == KIND_FR)
			&& bin_index != LAST_BIN
		|=> strobe && bin_index == $past(bin_index) + 4'd1)
		else $error("bin sequence broken");

	// first-reuse dump ends exactly at the last bin
	a_fr_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && report_kind == KIND_FR |-> last_of_run == (bin_index == LAST_BIN))
		else $error("first-reuse last flag wrong");
endmodule

bind reuse_interval_profiler rip_checker u_rip_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.strobe      (strobe),
	.report_kind (report_kind),
	.bin_index   (bin_index),
	.last_of_run (last_of_run)
);
